/* src/icf_pkg.sv */
// Shared types, widths and constants of the ICE connect/retry phase machine.
package icf_pkg;

  localparam int TIME_W     = 32;
  localparam int INTERVAL_W = 16;
  localparam int RETRY_W    = 16;
  localparam int TICKS_W    = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_INTERVAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETRIES    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CONNECT_TICKS  = 2'd2;

  // Configuration reset values
  localparam logic [INTERVAL_W-1:0] RETRY_INTERVAL_RST = 16'd1000;
  localparam logic [RETRY_W-1:0]    MAX_RETRIES_RST    = 16'd5;
  localparam logic [TICKS_W-1:0]    CONNECT_TICKS_RST  = 8'd3;

  typedef enum logic [2:0] {
    PH_NEW       = 3'd0,
    PH_GATHERING = 3'd1,
    PH_CHECKING  = 3'd2,
    PH_CONNECTED = 3'd3,
    PH_FAILED    = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_OFFER = 2'd2,
    CMD_CAND  = 2'd3
  } cmd_t;

  // One registered input event
  typedef struct packed {
    cmd_t              cmd;
    logic [TIME_W-1:0] now_ms;
    logic              offer_ok;
    logic              offer_has_candidates;
  } icf_item_t;

  // One result beat
  typedef struct packed {
    logic   emit_description;
    logic   emit_candidate;
    logic   connected_now;
    logic   retry_now;
    logic   failed_now;
    phase_t phase;
  } icf_result_t;

endpackage

/* src/icf_if.sv */
// Valid/ready channel interfaces for event input and result output.
interface icf_in_if;
  import icf_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        cmd;
  logic [TIME_W-1:0] now_ms;
  logic              offer_ok;
  logic              offer_has_candidates;

  modport source (output valid, cmd, now_ms, offer_ok, offer_has_candidates, input ready);
  modport sink   (input valid, cmd, now_ms, offer_ok, offer_has_candidates, output ready);
endinterface

interface icf_out_if;
  logic       valid;
  logic       ready;
  logic       emit_description;
  logic       emit_candidate;
  logic       connected_now;
  logic       retry_now;
  logic       failed_now;
  logic [2:0] phase;

  modport source (output valid, emit_description, emit_candidate, connected_now,
                  retry_now, failed_now, phase, input ready);
  modport sink   (input valid, emit_description, emit_candidate, connected_now,
                  retry_now, failed_now, phase, output ready);
endinterface

/* src/icf_in_stage.sv */
// Input register stage: captures one event beat per cycle while the core does not hold it.
module icf_in_stage (
  input  logic               clk,
  input  logic               rst,
  icf_in_if.sink             in_ch,
  output logic               item_valid,
  output icf_pkg::icf_item_t item,
  input  logic               item_ready
);
  import icf_pkg::*;

  // Stage is free when empty or when its content moves on this cycle
  assign in_ch.ready = !item_valid || item_ready;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ch.ready) begin
      item_valid <= in_ch.valid;
    end
  end

  // Payload capture
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item.cmd                  <= cmd_t'(in_ch.cmd);
      item.now_ms               <= in_ch.now_ms;
      item.offer_ok             <= in_ch.offer_ok;
      item.offer_has_candidates <= in_ch.offer_has_candidates;
    end
  end

endmodule

/* src/icf_core.sv */
// Phase machine, retry/connect counters, config registers and result register.
module icf_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  input  icf_pkg::icf_item_t              item,
  output logic                            item_ready,
  input  logic                            cfg_we,
  input  logic [icf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [icf_pkg::CFG_DATA_W-1:0]  cfg_data,
  icf_out_if.source                       out_ch
);
  import icf_pkg::*;

  // Configuration
  logic [INTERVAL_W-1:0] retry_gap_ms;
  logic [RETRY_W-1:0]    retry_limit;
  logic [TICKS_W-1:0]    connect_ticks_needed;

  // Link state
  phase_t                link_phase, link_phase_next;
  logic [TIME_W-1:0]     last_time, last_time_next;
  logic [TICKS_W-1:0]    connect_count, connect_count_next;
  logic [RETRY_W-1:0]    retries_done, retries_done_next;
  logic                  answer_built, answer_built_next;
  logic                  description_set, description_set_next;
  logic                  have_remote_candidate, have_remote_candidate_next;
  logic                  description_sent, description_sent_next;
  logic                  candidate_sent, candidate_sent_next;

  // Result register
  logic                  res_valid;
  icf_result_t           result, result_next;

  logic                  advance;
  logic [TIME_W-1:0]     elapsed;
  logic                  retry_due;
  logic [TICKS_W-1:0]    count_inc;
  logic                  emit_desc;
  logic                  emit_cand;

  assign item_ready = !res_valid || out_ch.ready;
  assign advance    = item_valid && item_ready;

  // Shared datapath terms
  assign elapsed   = item.now_ms - last_time;
  assign retry_due = elapsed >= {{(TIME_W-INTERVAL_W){1'b0}}, retry_gap_ms};
  assign count_inc = (connect_count < connect_ticks_needed) ?
                     TICKS_W'(connect_count + 8'd1) : connect_count;
  assign emit_desc = answer_built && !description_sent;
  assign emit_cand = answer_built && !candidate_sent;

  // Next state and result
  always_comb begin
    link_phase_next            = link_phase;
    last_time_next             = last_time;
    connect_count_next         = connect_count;
    retries_done_next          = retries_done;
    answer_built_next          = answer_built;
    description_set_next       = description_set;
    have_remote_candidate_next = have_remote_candidate;
    description_sent_next      = description_sent;
    candidate_sent_next        = candidate_sent;
    result_next                = '0;

    if (item_valid) begin
      unique case (item.cmd)
        CMD_START: begin
          description_sent_next = 1'b0;
          candidate_sent_next   = 1'b0;
          connect_count_next    = '0;
          retries_done_next     = '0;
          link_phase_next       = PH_GATHERING;
          last_time_next        = item.now_ms;
        end
        CMD_TICK: begin
          unique case (link_phase)
            PH_GATHERING: begin
              result_next.emit_description = emit_desc;
              result_next.emit_candidate   = emit_cand;
              if (emit_desc) description_sent_next = 1'b1;
              if (emit_cand) candidate_sent_next   = 1'b1;
              link_phase_next = PH_CHECKING;
              last_time_next  = item.now_ms;
            end
            PH_CHECKING: begin
              result_next.emit_description = emit_desc;
              result_next.emit_candidate   = emit_cand;
              if (emit_desc) description_sent_next = 1'b1;
              if (emit_cand) candidate_sent_next   = 1'b1;
              if (description_set) begin
                if (have_remote_candidate) begin
                  connect_count_next = count_inc;
                  if (count_inc >= connect_ticks_needed) begin
                    link_phase_next           = PH_CONNECTED;
                    result_next.connected_now = 1'b1;
                  end
                end else if (retry_due) begin
                  last_time_next = item.now_ms;
                  if (retries_done < retry_limit) begin
                    retries_done_next     = RETRY_W'(retries_done + 16'd1);
                    result_next.retry_now = 1'b1;
                  end else begin
                    link_phase_next        = PH_FAILED;
                    result_next.failed_now = 1'b1;
                  end
                end
              end
            end
            default: ;  // new, connected, failed: tick has no effect
          endcase
        end
        CMD_OFFER: begin
          description_sent_next      = 1'b0;
          candidate_sent_next        = 1'b0;
          connect_count_next         = '0;
          retries_done_next          = '0;
          answer_built_next          = item.offer_ok;
          description_set_next       = item.offer_ok;
          have_remote_candidate_next = item.offer_has_candidates;
        end
        CMD_CAND: begin
          have_remote_candidate_next = 1'b1;
        end
      endcase
    end

    result_next.phase = link_phase_next;
  end

  // State register, updated as each event leaves the input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      link_phase            <= PH_NEW;
      last_time             <= '0;
      connect_count         <= '0;
      retries_done          <= '0;
      answer_built          <= 1'b0;
      description_set       <= 1'b0;
      have_remote_candidate <= 1'b0;
      description_sent      <= 1'b0;
      candidate_sent        <= 1'b0;
    end else if (advance) begin
      link_phase            <= link_phase_next;
      last_time             <= last_time_next;
      connect_count         <= connect_count_next;
      retries_done          <= retries_done_next;
      answer_built          <= answer_built_next;
      description_set       <= description_set_next;
      have_remote_candidate <= have_remote_candidate_next;
      description_sent      <= description_sent_next;
      candidate_sent        <= candidate_sent_next;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      retry_gap_ms         <= RETRY_INTERVAL_RST;
      retry_limit          <= MAX_RETRIES_RST;
      connect_ticks_needed <= CONNECT_TICKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RETRY_INTERVAL: retry_gap_ms         <= cfg_data;
        CFG_MAX_RETRIES:    retry_limit          <= cfg_data;
        CFG_CONNECT_TICKS:  connect_ticks_needed <= cfg_data[TICKS_W-1:0];
        default: ;  // unmapped index
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (item_ready) begin
      res_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  // Output beat
  assign out_ch.valid            = res_valid;
  assign out_ch.emit_description = result.emit_description;
  assign out_ch.emit_candidate   = result.emit_candidate;
  assign out_ch.connected_now    = result.connected_now;
  assign out_ch.retry_now        = result.retry_now;
  assign out_ch.failed_now       = result.failed_now;
  assign out_ch.phase            = result.phase;

  // Checks
  a_one_outcome: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> $countones({result.connected_now, result.retry_now,
                              result.failed_now}) <= 1)
    else $error("more than one tick outcome in one result");

  a_failed_sticky: assert property (@(posedge clk) disable iff (rst)
    (link_phase == PH_FAILED && !(advance && item.cmd == CMD_START))
      |=> link_phase == PH_FAILED)
    else $error("failed phase left without a start event");

  a_new_sticky: assert property (@(posedge clk) disable iff (rst)
    (link_phase == PH_NEW && !(advance && item.cmd == CMD_START))
      |=> link_phase == PH_NEW)
    else $error("new phase left without a start event");

  a_nontick_quiet: assert property (@(posedge clk) disable iff (rst)
    (advance && item.cmd != CMD_TICK)
      |=> {result.emit_description, result.emit_candidate, result.connected_now,
           result.retry_now, result.failed_now} == 5'b0)
    else $error("non-tick event raised a tick flag");

endmodule

/* src/ice_connect_retry_fsm_top.sv */
// Top level of the ICE connect/retry phase machine.
// Takes one event beat per clock while the output is not stalled and returns exactly
// one result beat per event: an input register feeds a single pass through the phase
// logic (one 32-bit wrapping time difference and compare, small counter increments)
// into the result register. Events are applied to the link state in acceptance order;
// a stalled output holds both stages and backs up in_ch. Configuration writes
// (cfg_we/cfg_index/cfg_data) take effect the next cycle and are meant to be issued
// only while no event is in flight.
module ice_connect_retry_fsm_top (
  input  logic                            clk,
  input  logic                            rst,
  icf_in_if.sink                          in_ch,
  icf_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [icf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [icf_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import icf_pkg::*;

  logic      item_valid;
  logic      item_ready;
  icf_item_t item;

  // Input register
  icf_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .item_valid (item_valid),
    .item       (item),
    .item_ready (item_ready)
  );

  // Phase logic and result register
  icf_core u_core (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .item_ready (item_ready),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_ch     (out_ch)
  );

endmodule
